[rtl/vbpa_pkg.sv]
package vbpa_pkg;

  localparam int MaxDim    = 1024;
  localparam int FieldW    = 11;                  // raw register and coordinate width
  localparam int CoordW    = $clog2(MaxDim);      // source coordinate width
  localparam int OffW      = FieldW + 2;          // signed axis offset
  localparam int RowW      = 2 * CoordW;          // z*ny + y
  localparam int IndexW    = 3 * CoordW;          // linear source index
  localparam int InDataW   = 40;                  // three coordinates, padded to bytes
  localparam int OutDataW  = 64;                  // coords and index, padded to bytes
  localparam int OutUserW  = 3;
  localparam int CfgIndexW = 3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_IN_SIZE_X  = 3'd0,
    REG_IN_SIZE_Y  = 3'd1,
    REG_IN_SIZE_Z  = 3'd2,
    REG_LEAD_PAD_X = 3'd3,
    REG_LEAD_PAD_Y = 3'd4,
    REG_LEAD_PAD_Z = 3'd5,
    REG_MIRROR     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CoordW-1:0] coord;
    logic              outside;
    logic              clip;
  } axis_res_t;

  // extent of zero counts as one, above the maximum as the maximum
  function automatic logic [FieldW-1:0] eff_size(input logic [FieldW-1:0] raw);
    logic [FieldW-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = FieldW'(1);
    end else if (raw > FieldW'(MaxDim)) begin
      v = FieldW'(MaxDim);
    end
    return v;
  endfunction

  // symmetric reflection about the input edges, clamped into [0, n-1]
  function automatic axis_res_t reflect(input logic signed [OffW-1:0] off,
                                        input logic [FieldW-1:0] n);
    axis_res_t         res;
    logic signed [OffW-1:0] n_s;
    logic signed [OffW-1:0] r;
    n_s = $signed({2'b00, n});
    res.outside = 1'b0;
    res.clip    = 1'b0;
    r = off;
    if (off < 0) begin
      res.outside = 1'b1;
      r = ~off;
      if (r >= n_s) begin
        r = n_s - OffW'(1);
        res.clip = 1'b1;
      end
    end else if (off >= n_s) begin
      res.outside = 1'b1;
      r = $signed({1'b0, n, 1'b0}) - OffW'(1) - off;
      if (r < 0) begin
        r = '0;
        res.clip = 1'b1;
      end
    end
    res.coord = r[CoordW-1:0];
    return res;
  endfunction

endpackage

[rtl/volume_border_padding_address.sv]
// Source address generator for a padded 3D volume.
// Slave stream: one output voxel coordinate per transaction (out_x, out_y, out_z).
// Master stream: one result per transaction: source coordinate and linear source
// index (z*ny + y)*nx + x in tdata, border/constant/clamp flags in tuser.
// Border voxels are zero-filled flagged in constant mode, reflected about the
// input edges in mirror mode; reflections still out of range are clamped.
// Configuration: cfg_we writes cfg_data into register cfg_index (sizes, lead pads,
// mirror mode); write only while no transaction is in flight.
// From input acceptance to the master side a result passes the offset stage,
// reflect stage, row multiply stage, and index multiply and output register.
// Throughput: one transaction per cycle while m_tready does not stall, set by the
// fully pipelined datapath with one multiplier in each of the last two stages.
// Reset clears all valid bits and loads sizes 1, pads 0, constant mode.
// A stall on the master side freezes every stage; s_tready drops only while the
// output register holds an untaken result, so nothing is lost or repeated.
module volume_border_padding_address (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vbpa_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [vbpa_pkg::FieldW-1:0]          cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // out_x [10:0], out_y [21:11], out_z [32:22], zero [39:33]
  input  logic [vbpa_pkg::InDataW-1:0]         s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // src_x [9:0], src_y [19:10], src_z [29:20], src_index [59:30], zero [63:60]
  output logic [vbpa_pkg::OutDataW-1:0]        m_tdata,
  // in_border [0], use_constant [1], clamped [2]
  output logic [vbpa_pkg::OutUserW-1:0]        m_tuser
);
  import vbpa_pkg::*;

  logic [FieldW-1:0] in_size_x, in_size_y, in_size_z;
  logic [FieldW-1:0] lead_pad_x, lead_pad_y, lead_pad_z;
  logic              mirror_mode;
  logic [FieldW-1:0] nx, ny, nz;

  logic ce;

  // stage 1: axis offsets
  logic                   v1;
  logic signed [OffW-1:0] off_x, off_y, off_z;

  // stage 2: reflected coordinates
  logic              v2;
  logic [CoordW-1:0] sx2, sy2, sz2;
  logic              border2, cst2, clip2;

  // stage 3: row product
  logic              v3;
  logic [CoordW-1:0] sx3, sy3, sz3;
  logic              border3, cst3, clip3;
  logic [RowW-1:0]   row3;

  axis_res_t rx, ry, rz;
  logic [2*FieldW-1:0] row_full;
  logic [RowW+FieldW:0] idx_full;

  logic [CoordW-1:0] src_x, src_y, src_z;
  logic [IndexW-1:0] src_index;
  logic              in_border, use_constant, clamped;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  assign rx = reflect(off_x, nx);
  assign ry = reflect(off_y, ny);
  assign rz = reflect(off_z, nz);

  assign row_full = (2*FieldW)'(sz2) * (2*FieldW)'(ny) + (2*FieldW)'(sy2);
  assign idx_full = (RowW+FieldW+1)'(row3) * (RowW+FieldW+1)'(nx)
                  + (RowW+FieldW+1)'(sx3);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_size_x   <= FieldW'(1);
      in_size_y   <= FieldW'(1);
      in_size_z   <= FieldW'(1);
      lead_pad_x  <= '0;
      lead_pad_y  <= '0;
      lead_pad_z  <= '0;
      mirror_mode <= 1'b0;
      nx          <= FieldW'(1);
      ny          <= FieldW'(1);
      nz          <= FieldW'(1);
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_IN_SIZE_X:  in_size_x   <= cfg_data;
          REG_IN_SIZE_Y:  in_size_y   <= cfg_data;
          REG_IN_SIZE_Z:  in_size_z   <= cfg_data;
          REG_LEAD_PAD_X: lead_pad_x  <= cfg_data;
          REG_LEAD_PAD_Y: lead_pad_y  <= cfg_data;
          REG_LEAD_PAD_Z: lead_pad_z  <= cfg_data;
          REG_MIRROR:     mirror_mode <= cfg_data[0];
          default: ;
        endcase
      end
      nx <= eff_size(in_size_x);
      ny <= eff_size(in_size_y);
      nz <= eff_size(in_size_z);
      if (ce) begin
        v1       <= s_tvalid;
        v2       <= v1;
        v3       <= v2;
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      off_x <= $signed({2'b00, s_tdata[FieldW-1:0]})
             - $signed({{2{lead_pad_x[FieldW-1]}}, lead_pad_x});
      off_y <= $signed({2'b00, s_tdata[2*FieldW-1:FieldW]})
             - $signed({{2{lead_pad_y[FieldW-1]}}, lead_pad_y});
      off_z <= $signed({2'b00, s_tdata[3*FieldW-1:2*FieldW]})
             - $signed({{2{lead_pad_z[FieldW-1]}}, lead_pad_z});

      sx2     <= rx.coord;
      sy2     <= ry.coord;
      sz2     <= rz.coord;
      border2 <= rx.outside || ry.outside || rz.outside;
      cst2    <= (rx.outside || ry.outside || rz.outside) && !mirror_mode;
      clip2   <= rx.clip || ry.clip || rz.clip;

      sx3     <= sx2;
      sy3     <= sy2;
      sz3     <= sz2;
      border3 <= border2;
      cst3    <= cst2;
      clip3   <= clip2;
      row3    <= row_full[RowW-1:0];

      // constant border voxels carry zero coordinates and index
      in_border    <= border3;
      use_constant <= cst3;
      clamped      <= clip3 && !cst3;
      src_x        <= cst3 ? '0 : sx3;
      src_y        <= cst3 ? '0 : sy3;
      src_z        <= cst3 ? '0 : sz3;
      src_index    <= cst3 ? '0 : idx_full[IndexW-1:0];
    end
  end

  assign m_tdata = {(OutDataW - IndexW - 3*CoordW)'(0), src_index, src_z, src_y, src_x};
  assign m_tuser = {clamped, use_constant, in_border};

  a_const_is_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && use_constant |-> in_border)
    else $error("constant result outside the border");

  a_const_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && use_constant |-> (src_index == '0) && !clamped)
    else $error("constant result carries a source address");

  a_clamp_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && clamped |-> in_border && !use_constant)
    else $error("clamp flagged on an inside voxel");

  a_src_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !use_constant |->
      ({1'b0, src_x} < nx) && ({1'b0, src_y} < ny) && ({1'b0, src_z} < nz))
    else $error("source coordinate beyond the input extent");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import vbpa_pkg::*;

  localparam logic [CfgIndexW-1:0] UnmappedReg = 3'd7;
  localparam int WatchdogLimit = 2000;
  localparam int RandomVoxels = 950;

  typedef struct {
    logic        in_border;
    logic        use_const;
    logic        clamped;
    logic [9:0]  src_x;
    logic [9:0]  src_y;
    logic [9:0]  src_z;
    logic [29:0] src_index;
  } voxel_src_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [FieldW-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic [OutUserW-1:0]  m_tuser;

  // shadow copy of the block's registers, index 0..2 is x, y, z
  logic [FieldW-1:0] size_reg [3] = '{11'd1, 11'd1, 11'd1};
  logic [FieldW-1:0] pad_reg [3] = '{11'd0, 11'd0, 11'd0};
  logic              mirror_reg = 1'b0;

  voxel_src_t pending_src_q [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         rx_stall = 0;
  bit         gaps_on = 1'b1;

  volume_border_padding_address i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int extent_of(input logic [FieldW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MaxDim) return MaxDim;
    return int'(raw);
  endfunction

  function automatic voxel_src_t locate_source(input logic [FieldW-1:0] ox,
                                               input logic [FieldW-1:0] oy,
                                               input logic [FieldW-1:0] oz);
    voxel_src_t        res;
    logic [FieldW-1:0] coord [3];
    int                ext [3];
    int                src [3];
    int                off;
    logic              outside;
    logic              clip;
    longint            lin;
    coord[0] = ox;
    coord[1] = oy;
    coord[2] = oz;
    outside = 1'b0;
    clip = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ext[a] = extent_of(size_reg[a]);
      off = int'(coord[a]) - int'($signed(pad_reg[a]));
      src[a] = off;
      if (off < 0 || off >= ext[a]) begin
        outside = 1'b1;
        src[a] = (off < 0) ? -1 - off : 2 * ext[a] - off - 1;
        if (src[a] < 0) begin
          src[a] = 0;
          clip = 1'b1;
        end
        if (src[a] >= ext[a]) begin
          src[a] = ext[a] - 1;
          clip = 1'b1;
        end
      end
    end
    res.in_border = outside;
    if (outside && !mirror_reg) begin
      res.use_const = 1'b1;
      res.clamped = 1'b0;
      res.src_x = '0;
      res.src_y = '0;
      res.src_z = '0;
      res.src_index = '0;
    end else begin
      lin = (longint'(src[2]) * ext[1] + src[1]) * ext[0] + src[0];
      res.use_const = 1'b0;
      res.clamped = clip;
      res.src_x = 10'(src[0]);
      res.src_y = 10'(src[1]);
      res.src_z = 10'(src[2]);
      res.src_index = 30'(lin);
    end
    return res;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [FieldW-1:0] pick_extent();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'($urandom_range(1025, 2047));
      4: return 11'($urandom_range(1, 1024));
      default: return 11'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [FieldW-1:0] pick_pad();
    case ($urandom_range(0, 5))
      0: return 11'h400;
      1: return 11'h3FF;
      2: return 11'($urandom);
      3: return 11'd0;
      default: return 11'($urandom_range(0, 24) - 12);
    endcase
  endfunction

  // mostly just around the input volume so that every edge gets hit
  function automatic logic [FieldW-1:0] pick_coord(input logic [FieldW-1:0] pad,
                                                   input logic [FieldW-1:0] size);
    int n;
    n = extent_of(size);
    if ($urandom_range(0, 3) == 0) return 11'($urandom);
    return 11'(int'($signed(pad)) + int'($urandom_range(0, 3 * n + 3)) - (n + 2));
  endfunction

  task automatic send_voxel(input logic [FieldW-1:0] ox, input logic [FieldW-1:0] oy,
                            input logic [FieldW-1:0] oz);
    int gap;
    gap = gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, oz, oy, ox};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_src_q.push_back(locate_source(ox, oy, oz));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_src_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] idx,
                                input logic [FieldW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_IN_SIZE_X:  size_reg[0] = value;
      REG_IN_SIZE_Y:  size_reg[1] = value;
      REG_IN_SIZE_Z:  size_reg[2] = value;
      REG_LEAD_PAD_X: pad_reg[0] = value;
      REG_LEAD_PAD_Y: pad_reg[1] = value;
      REG_LEAD_PAD_Z: pad_reg[2] = value;
      REG_MIRROR:     mirror_reg = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [FieldW-1:0] sx, input logic [FieldW-1:0] sy,
                               input logic [FieldW-1:0] sz, input logic [FieldW-1:0] px,
                               input logic [FieldW-1:0] py, input logic [FieldW-1:0] pz,
                               input logic mirror);
    wait_drained();
    write_register(REG_IN_SIZE_X, sx);
    write_register(REG_IN_SIZE_Y, sy);
    write_register(REG_IN_SIZE_Z, sz);
    write_register(REG_LEAD_PAD_X, px);
    write_register(REG_LEAD_PAD_Y, py);
    write_register(REG_LEAD_PAD_Z, pz);
    // upper data bits are junk, only bit 0 counts
    write_register(REG_MIRROR, {10'($urandom), mirror});
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_voxel(11'd0, 11'd0, 11'd0);
    send_voxel(11'd1, 11'd0, 11'd0);
    send_voxel(11'd2047, 11'd2047, 11'd2047);
  endtask

  task automatic test_unmapped_register();
    wait_drained();
    write_register(UnmappedReg, 11'($urandom));
    cfg_we <= 1'b0;
    send_voxel(11'd0, 11'd0, 11'd0);
    send_voxel(11'd0, 11'd3, 11'd0);
  endtask

  task automatic test_constant_border();
    apply_setting(11'd5, 11'd7, 11'd3, 11'd2, 11'h7FF, 11'd0, 1'b0);
    send_voxel(11'd2, 11'd0, 11'd0);
    send_voxel(11'd6, 11'd6, 11'd2);
    send_voxel(11'd1, 11'd0, 11'd0);
    send_voxel(11'd7, 11'd0, 11'd0);
    send_voxel(11'd2, 11'd7, 11'd0);
    send_voxel(11'd2, 11'd0, 11'd3);
  endtask

  task automatic test_mirror_reflect();
    apply_setting(11'd4, 11'd4, 11'd4, 11'd3, 11'd3, 11'd3, 1'b1);
    send_voxel(11'd2, 11'd3, 11'd3);
    send_voxel(11'd0, 11'd3, 11'd3);
    send_voxel(11'd7, 11'd3, 11'd3);
    send_voxel(11'd9, 11'd3, 11'd3);
    send_voxel(11'd10, 11'd6, 11'd3);
    send_voxel(11'd0, 11'd0, 11'd11);
  endtask

  task automatic test_extreme_settings();
    // zero extent acts as one, oversize as the maximum; pads at both limits
    apply_setting(11'd0, 11'd2047, 11'd1024, 11'h400, 11'h3FF, 11'd0, 1'b1);
    send_voxel(11'd0, 11'd0, 11'd0);
    send_voxel(11'd2047, 11'd2047, 11'd2047);
    send_voxel(11'd0, 11'd1023, 11'd1023);
    // reflection below zero that lands past the far edge
    apply_setting(11'd2, 11'd1, 11'd1024, 11'h3FF, 11'd0, 11'h400, 1'b1);
    send_voxel(11'd0, 11'd0, 11'd0);
    send_voxel(11'd1023, 11'd0, 11'd1023);
    apply_setting(11'd1024, 11'd1024, 11'd1024, 11'd0, 11'd0, 11'd0, 1'b0);
    send_voxel(11'd1023, 11'd1023, 11'd1023);
    send_voxel(11'd2047, 11'd0, 11'd0);
  endtask

  task automatic test_random_traffic();
    int n_sent;
    int batch;
    n_sent = 0;
    while (n_sent < RandomVoxels) begin
      apply_setting(pick_extent(), pick_extent(), pick_extent(),
                    pick_pad(), pick_pad(), pick_pad(), 1'($urandom));
      gaps_on = ($urandom_range(0, 3) != 0);
      batch = $urandom_range(40, 110);
      repeat (batch) begin
        send_voxel(pick_coord(pad_reg[0], size_reg[0]),
                   pick_coord(pad_reg[1], size_reg[1]),
                   pick_coord(pad_reg[2], size_reg[2]));
      end
      n_sent += batch;
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin : rx_side
    voxel_src_t want;
    voxel_src_t seen;
    int         gap;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.in_border = m_tuser[0];
        seen.use_const = m_tuser[1];
        seen.clamped = m_tuser[2];
        seen.src_x = m_tdata[9:0];
        seen.src_y = m_tdata[19:10];
        seen.src_z = m_tdata[29:20];
        seen.src_index = m_tdata[59:30];
        if (pending_src_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result with nothing expected");
        end else begin
          want = pending_src_q.pop_front();
          if (seen.in_border !== want.in_border || seen.use_const !== want.use_const ||
              seen.clamped !== want.clamped || seen.src_x !== want.src_x ||
              seen.src_y !== want.src_y || seen.src_z !== want.src_z ||
              seen.src_index !== want.src_index) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected border %0b const %0b clamp %0b src %0d,%0d,%0d idx %0d",
                       want.in_border, want.use_const, want.clamped,
                       want.src_x, want.src_y, want.src_z, want.src_index);
              $display("          got      border %0b const %0b clamp %0b src %0d,%0d,%0d idx %0d",
                       seen.in_border, seen.use_const, seen.clamped,
                       seen.src_x, seen.src_y, seen.src_z, seen.src_index);
            end
          end
        end
      end
      if (!gaps_on) begin
        m_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall <= rx_stall - 1;
      end else begin
        gap = idle_length();
        if (gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          rx_stall <= gap - 1;
        end
      end
    end
  end

  // cycles without any transaction or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_unmapped_register();
    test_constant_border();
    test_mirror_reflect();
    test_extreme_settings();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vbpa_pkg.sv
rtl/volume_border_padding_address.sv
test/tb.sv
